>>> hdl/cbpt_pkg.sv
// Shared types and constants for the countdown bar pixel timer.
// Used by the controller, the datapath, the top level and the port checker.
package cbpt_pkg;

  // Field and register widths
  localparam int unsigned DUR_W     = 24;
  localparam int unsigned PIX_W     = 7;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = DUR_W;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;

  // Pixels per layer saturate to this value
  localparam logic [PIX_W-1:0] MAX_LAYER_PIXELS = PIX_W'(64);

  // Divider: elapsed * pixels is DUR_W + PIX_W bits; quotient is below pixels
  localparam int unsigned PROD_W    = DUR_W + PIX_W;
  localparam int unsigned DIV_STEPS = PIX_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // Reset values of the configuration registers
  localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(1000);
  localparam logic [PIX_W-1:0] PIX_RESET = PIX_W'(24);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS   = 1'b1;

  // Input actions
  typedef enum logic [ACT_W-1:0] {
    ACT_START = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_ABORT = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;       // latch the accepted input item
    logic arm;        // start: latch start time, clear steps, run
    logic disarm;     // stop and clear steps
    logic sub;        // register elapsed time
    logic mul;        // load product and set up the divider
    logic div_step;   // one restoring division step
    logic emit_pix;   // load a pixel-off result
    logic emit_fin;   // load a finished result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    action_t act;
    logic    running;
    logic    expired;
    logic    div_last;
    logic    more;
    logic    last_pix;
    logic    out_free;
  } sts_t;

endpackage

>>> hdl/cbpt_ctrl.sv
// Controller state machine for the countdown bar pixel timer.
// Depends on cbpt_pkg for the command and status structs.
module cbpt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  cbpt_pkg::sts_t sts,
  output cbpt_pkg::cmd_t cmd
);
  import cbpt_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_CHECK  = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_EMIT   = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.sub = 1'b1;
        case (sts.act)
          ACT_START: begin
            cmd.arm   = 1'b1;
            state_nxt = ST_IDLE;
          end
          ACT_ABORT: begin
            cmd.disarm = 1'b1;
            state_nxt  = ST_IDLE;
          end
          ACT_TICK: begin
            state_nxt = sts.running ? ST_CHECK : ST_IDLE;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_CHECK: begin
        if (sts.expired) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.more) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_pix = 1'b1;
          if (sts.last_pix) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.emit_fin = 1'b1;
          cmd.disarm   = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/cbpt_dp.sv
// Datapath for the countdown bar pixel timer: configuration, timer state,
// multiplier, restoring divider and result register. Depends on cbpt_pkg.
module cbpt_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cbpt_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [cbpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [cbpt_pkg::ACT_W-1:0]      in_action,
  input  logic [cbpt_pkg::TIME_W-1:0]     in_now_ms,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cbpt_pkg::PIX_W-1:0]      out_pixel_index,
  output logic [cbpt_pkg::PIX_W-1:0]      out_mirror_index,
  output logic                            out_finished,
  output logic                            out_last,
  input  cbpt_pkg::cmd_t                  cmd,
  output cbpt_pkg::sts_t                  sts
);
  import cbpt_pkg::*;

  logic [DUR_W-1:0]  dur_r;
  logic [PIX_W-1:0]  pix_cfg_r;
  logic              running_r;
  logic [TIME_W-1:0] start_r;
  logic [PIX_W-1:0]  steps_r;
  action_t           act_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [PROD_W-1:0] rem_r;
  logic [PROD_W-1:0] dvs_r;
  logic [PIX_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic [PIX_W-1:0]  out_mir_r;
  logic              out_fin_r;
  logic              out_last_r;

  logic [PIX_W-1:0]  pixels;
  logic              ge;
  logic [PIX_W:0]    mirror_full;
  logic [PIX_W:0]    steps_inc;

  // Saturate the pixel count
  assign pixels = (pix_cfg_r > MAX_LAYER_PIXELS) ? MAX_LAYER_PIXELS : pix_cfg_r;

  assign ge          = (rem_r >= dvs_r);
  assign mirror_full = {pixels, 1'b0} - (PIX_W+1)'(1) - {1'b0, steps_r};
  assign steps_inc   = {1'b0, steps_r} + (PIX_W+1)'(1);

  // Status to the controller
  always_comb begin
    sts.act      = act_r;
    sts.running  = running_r;
    sts.expired  = (elapsed_r >= TIME_W'(dur_r));
    sts.div_last = (cnt_r == '0);
    sts.more     = (steps_r < quo_r);
    sts.last_pix = (steps_inc == {1'b0, quo_r});
    sts.out_free = !out_valid_r || out_tready;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r     <= DUR_RESET;
      pix_cfg_r <= PIX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DURATION: dur_r     <= cfg_wdata;
        REG_PIXELS:   pix_cfg_r <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      start_r   <= '0;
      steps_r   <= '0;
    end else begin
      if (cmd.arm) begin
        running_r <= 1'b1;
        start_r   <= now_r;
        steps_r   <= '0;
      end else if (cmd.disarm) begin
        running_r <= 1'b0;
        steps_r   <= '0;
      end else if (cmd.emit_pix) begin
        steps_r   <= steps_inc[PIX_W-1:0];
      end
    end
  end

  // Input latch, elapsed time, product and divider
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act_r <= action_t'(in_action);
      now_r <= in_now_ms;
    end
    if (cmd.sub) begin
      elapsed_r <= now_r - start_r;
    end
    if (cmd.mul) begin
      // elapsed is below the duration here, so it fits DUR_W bits
      rem_r <= PROD_W'(elapsed_r[DUR_W-1:0]) * PROD_W'(pixels);
      dvs_r <= PROD_W'(dur_r) << (DIV_STEPS - 1);
      quo_r <= '0;
      cnt_r <= CNT_W'(DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      if (ge) begin
        rem_r <= rem_r - dvs_r;
      end
      dvs_r <= dvs_r >> 1;
      quo_r <= {quo_r[PIX_W-2:0], ge};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Result register: hold until transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_pix || cmd.emit_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pix) begin
      out_pix_r  <= steps_r;
      out_mir_r  <= mirror_full[PIX_W-1:0];
      out_fin_r  <= 1'b0;
      out_last_r <= sts.last_pix;
    end else if (cmd.emit_fin) begin
      out_pix_r  <= '0;
      out_mir_r  <= '0;
      out_fin_r  <= 1'b1;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid       = out_valid_r;
  assign out_pixel_index  = out_pix_r;
  assign out_mirror_index = out_mir_r;
  assign out_finished     = out_fin_r;
  assign out_last         = out_last_r;

endmodule

>>> hdl/countdown_bar_pixel_timer_unit.sv
// Top level of the countdown bar pixel timer: stream ports, configuration
// port, controller and datapath. Depends on cbpt_pkg, cbpt_ctrl, cbpt_dp.
//
// One input item at a time. A start, an abort, an unused action or a tick
// while disarmed is taken and decoded. A tick that expires is decoded and
// checked, then waits for the result slot. Other ticks are decoded and
// checked, run the restoring divider (one quotient bit per cycle) and emit
// pixel-off results, one per cycle while the result slot is free, or none
// when no new step is passed.
// The result register holds one result, so a new item is taken while the
// last result of the previous one still waits to be transferred.
module countdown_bar_pixel_timer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration
  input  logic                             cfg_we,
  input  logic [cbpt_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [cbpt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cbpt_pkg::IN_DATA_W-1:0]   in_tdata,   // [31:0] now_ms
  input  logic [cbpt_pkg::ACT_W-1:0]       in_tuser,   // [1:0] action
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cbpt_pkg::OUT_DATA_W-1:0]  out_tdata,  // [6:0] pixel_index,
                                                       // [13:7] mirror_index,
                                                       // [15:14] zero
  output logic                             out_tuser,  // [0] finished
  output logic                             out_tlast
);
  import cbpt_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [PIX_W-1:0] pix_idx;
  logic [PIX_W-1:0] mir_idx;

  cbpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbpt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_action        (in_tuser),
    .in_now_ms        (in_tdata[TIME_W-1:0]),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_pixel_index  (pix_idx),
    .out_mirror_index (mir_idx),
    .out_finished     (out_tuser),
    .out_last         (out_tlast),
    .cmd              (cmd),
    .sts              (sts)
  );

  // Pack the result fields
  assign out_tdata = {(OUT_DATA_W - 2*PIX_W)'(0), mir_idx, pix_idx};

endmodule

>>> hdl/cbpt_chk.sv
// Port-level checker for the countdown bar pixel timer, bound to the top.
// Depends on cbpt_pkg and countdown_bar_pixel_timer_unit.
module cbpt_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cbpt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);
  import cbpt_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Finished result ends its run
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("finished result without last");

  // Finished result carries zero indices
  a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[2*PIX_W-1:0] == '0)
    else $error("finished result with nonzero index");

  // Mirror index lies in the second layer, above the pixel index
  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[2*PIX_W-1:PIX_W] > out_tdata[PIX_W-1:0])
    else $error("mirror index not above pixel index");

endmodule

bind countdown_bar_pixel_timer_unit cbpt_chk u_cbpt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> verif/cbpt_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the countdown bar pixel timer: watches the config port
// and both stream channels, predicts pixel-off/finished results and compares.
// Depends on cbpt_pkg for widths, register indexes and action codes.
module cbpt_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cbpt_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [cbpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [cbpt_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] now_ms
  input  logic [cbpt_pkg::ACT_W-1:0]      in_tuser,   // [1:0] action
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [cbpt_pkg::OUT_DATA_W-1:0] out_tdata,  // [6:0] pixel_index,
                                                      // [13:7] mirror_index,
                                                      // [15:14] zero
  input  logic                            out_tuser,  // [0] finished
  input  logic                            out_tlast,
  output int                              fail_count,
  output int                              pending_count
);
  import cbpt_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] mir;
    logic             fin;
    logic             lst;
  } strip_result_t;

  // Results still owed by the block, oldest first
  strip_result_t    due_results[$];

  // Shadow of the timer configuration and state
  logic [DUR_W-1:0]  duration;
  logic [PIX_W-1:0]  pixels;
  logic              armed;
  logic [TIME_W-1:0] t_start;
  logic [PIX_W-1:0]  steps;
  int                errors = 0;

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // Advance the shadow timer by one input transfer and queue its results
  task automatic predict_strip_update(action_t act, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] elapsed;
    logic [PIX_W-1:0]  lim;
    logic [63:0]       target;
    logic [PIX_W-1:0]  stop;
    strip_result_t     r;
    case (act)
      ACT_START: begin
        t_start = now;
        steps   = '0;
        armed   = 1'b1;
      end
      ACT_ABORT: begin
        armed = 1'b0;
        steps = '0;
      end
      ACT_TICK: begin
        if (armed) begin
          elapsed = now - t_start;
          if (elapsed >= {8'b0, duration}) begin
            // expired: one finished result with zero indexes
            armed = 1'b0;
            steps = '0;
            r = '0;
            r.fin = 1'b1;
            r.lst = 1'b1;
            due_results.push_back(r);
          end else begin
            // duration is nonzero here since elapsed is below it
            lim    = (pixels > MAX_LAYER_PIXELS) ? MAX_LAYER_PIXELS : pixels;
            target = (64'(elapsed) * 64'(lim)) / 64'(duration);
            if (target > 64'(steps)) begin
              stop = (target < 64'(lim)) ? PIX_W'(target) : lim;
              for (int i = int'(steps); i < int'(stop); i++) begin
                r.pix = PIX_W'(i);
                r.mir = PIX_W'(2 * int'(lim) - 1 - i);
                r.fin = 1'b0;
                r.lst = (i == int'(stop) - 1);
                due_results.push_back(r);
              end
              steps = stop;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    strip_result_t want;
    if (!rst_n) begin
      duration = DUR_RESET;
      pixels   = PIX_RESET;
      armed    = 1'b0;
      t_start  = '0;
      steps    = '0;
      due_results.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        if (cfg_addr == REG_DURATION) begin
          duration = cfg_wdata[DUR_W-1:0];
        end else if (cfg_addr == REG_PIXELS) begin
          pixels = cfg_wdata[PIX_W-1:0];
        end
      end
      // Check a result transfer against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf(
            "result with nothing expected, tdata 0x%h tuser %b tlast %b",
            out_tdata, out_tuser, out_tlast));
        end else begin
          want = due_results.pop_front();
          compare_field("pixel_index", int'(out_tdata[6:0]), int'(want.pix));
          compare_field("mirror_index", int'(out_tdata[13:7]), int'(want.mir));
          compare_field("tdata pad", int'(out_tdata[15:14]), 0);
          compare_field("finished", int'(out_tuser), int'(want.fin));
          compare_field("last", int'(out_tlast), int'(want.lst));
        end
      end
      // Predict from an input transfer
      if (in_tvalid && in_tready) begin
        predict_strip_update(action_t'(in_tuser), in_tdata[TIME_W-1:0]);
      end
    end
    fail_count    <= errors;
    pending_count <= due_results.size();
  end

endmodule

>>> verif/countdown_bar_pixel_timer_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for countdown_bar_pixel_timer_unit: clock, reset, directed and
// random stimulus with random idling. Depends on cbpt_pkg and cbpt_result_checker.
module countdown_bar_pixel_timer_unit_tb;
  import cbpt_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [31:0] now_ms
  logic [ACT_W-1:0]      in_tuser;   // [1:0] action
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [6:0] pixel_index, [13:7] mirror_index, [15:14] zero
  logic                  out_tuser;  // [0] finished
  logic                  out_tlast;

  int                    mismatches;
  int                    results_due;
  logic                  tx_calm = 1'b1;
  logic                  rx_calm = 1'b1;

  // Stimulus scratch
  logic [TIME_W-1:0]     t0;
  logic [TIME_W-1:0]     st;
  longint                el;
  logic [DUR_W-1:0]      dur;
  logic [PIX_W-1:0]      pix;
  action_t               act;
  int                    rnd_items;
  int                    phase_left;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  countdown_bar_pixel_timer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  cbpt_result_checker result_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (mismatches),
    .pending_count (results_due)
  );

  // Offer one input item after a random gap and hold it until transferred
  task automatic send_item(action_t a, logic [TIME_W-1:0] now);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= a;
    in_tdata  <= now;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid, wait for every owed result, then let a silent item finish
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Write both registers in random order while the block is idle
  task automatic write_config(logic [DUR_W-1:0] d, logic [PIX_W-1:0] p);
    logic pix_first;
    logic sel_pix;
    settle();
    pix_first = 1'($urandom_range(0, 1));
    for (int k = 0; k < 2; k++) begin
      sel_pix   = (k == 0) ? pix_first : !pix_first;
      cfg_we    <= 1'b1;
      cfg_addr  <= sel_pix ? REG_PIXELS : REG_DURATION;
      cfg_wdata <= sel_pix ? CFG_DATA_W'(p) : d;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Result side: stall a random number of cycles before each transfer
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Hard stop for a hung run
  initial begin
    #14_400_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ACT_NONE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: disarmed tick and abort, unused action, wrapped time
    send_item(ACT_TICK, 32'h0000_1234);
    send_item(ACT_ABORT, 32'h0000_2000);
    send_item(ACT_NONE, 32'hFFFF_FFFF);
    t0 = 32'hFFFF_FF00;
    send_item(ACT_START, t0);
    send_item(ACT_TICK, t0 + 32'd500);
    send_item(ACT_TICK, t0 + 32'd500);
    send_item(ACT_TICK, t0 + 32'd999);
    // re-arm while armed, then abort and tick while disarmed
    send_item(ACT_START, 32'd100);
    send_item(ACT_TICK, 32'd142);
    send_item(ACT_ABORT, 32'd150);
    send_item(ACT_TICK, 32'd200);
    send_item(ACT_START, 32'd5000);
    send_item(ACT_TICK, 32'd6000);

    // Zero duration finishes on the first tick
    write_config(24'd0, 7'd1);
    send_item(ACT_START, 32'hAAAA_5555);
    send_item(ACT_TICK, 32'hAAAA_5555);

    // Longest duration with the widest layer
    write_config(24'hFF_FFFF, 7'd64);
    send_item(ACT_START, 32'd0);
    send_item(ACT_TICK, 32'h00FF_FFFE);
    send_item(ACT_TICK, 32'h00FF_FFFF);

    // Zero pixels: nothing until expiry
    write_config(24'd1000, 7'd0);
    send_item(ACT_START, 32'd0);
    send_item(ACT_TICK, 32'd999);
    send_item(ACT_TICK, 32'd1000);

    // Pixel count above the layer size saturates
    write_config(24'd1000, 7'd127);
    send_item(ACT_START, 32'd7);
    send_item(ACT_TICK, 32'd1006);
    // Shrink the layer mid-run: target below steps gives nothing
    write_config(24'd1000, 7'd10);
    send_item(ACT_TICK, 32'd1006);
    send_item(ACT_TICK, 32'd2007);

    // Shortest nonzero duration, single pixel
    write_config(24'd1, 7'd1);
    send_item(ACT_START, 32'd3);
    send_item(ACT_TICK, 32'd3);
    send_item(ACT_TICK, 32'd4);

    // Random phases: mostly start-and-tick runs, some noise
    rnd_items  = 0;
    phase_left = 0;
    while (rnd_items < 80) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 5))
          0: dur = 24'd0;
          1: dur = 24'hFF_FFFF;
          2: dur = DUR_W'($urandom_range(1, 200));
          3: dur = DUR_W'($urandom_range(1000, 100000));
          default: dur = DUR_W'($urandom);
        endcase
        case ($urandom_range(0, 6))
          0: pix = 7'd0;
          1: pix = 7'd1;
          2: pix = 7'd64;
          3: pix = 7'd127;
          4: pix = PIX_W'($urandom_range(0, 127));
          default: pix = PIX_W'($urandom_range(1, 64));
        endcase
        write_config(dur, pix);
        tx_calm    = ($urandom_range(0, 3) == 0);
        rx_calm    = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(3, 6);
      end
      if ($urandom_range(0, 4) != 0) begin
        st = $urandom;
        el = 0;
        send_item(ACT_START, st);
        rnd_items++;
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 11) == 0) begin
            send_item(ACT_ABORT, st + el[31:0]);
            rnd_items++;
          end
          // pick the next elapsed time: boundary, far jump or a forward step
          case ($urandom_range(0, 9))
            0: el = dur;
            1: el = (dur > 0) ? dur - 1 : 0;
            2: el = $urandom;
            default: el = el + $urandom_range(0, dur / 4 + 1);
          endcase
          send_item(ACT_TICK, st + el[31:0]);
          rnd_items++;
        end
      end else begin
        act = action_t'($urandom_range(0, 3));
        send_item(act, $urandom);
        if (act != ACT_NONE) rnd_items++;
      end
      // hold off now and then until the block has drained
      if ($urandom_range(0, 11) == 0) settle();
      phase_left--;
    end

    settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
